// File: hdl/positional_list_engine_assert.svh
// Assertion macros for the positional list engine.
// Used by modules that have clk_i and rst_ni in scope; no other dependencies.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define PLE_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define PLE_ASSERT_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: hdl/ple_pkg.sv
// Shared types for the positional list engine: request and result payloads,
// operation kinds and status codes. No dependencies.
package ple_pkg;

  // Operation kinds carried in the request
  typedef enum logic [2:0] {
    K_INS_HEAD = 3'd0,
    K_INS_TAIL = 3'd1,
    K_INS_AT   = 3'd2,
    K_DEL_HEAD = 3'd3,
    K_DEL_TAIL = 3'd4,
    K_DEL_AT   = 3'd5,
    K_SEARCH   = 3'd6
  } ple_kind_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BOUNDS   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } ple_status_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic [5:0]         position;
  } ple_req_t;

  typedef struct packed {
    ple_status_e status;
    logic [4:0]  found_index;
    logic [5:0]  length;
  } ple_result_t;

endpackage

// File: hdl/positional_list_engine.sv
// Positional list engine: bounded ordered list of signed 32-bit values.
// One request in, one result out, valid/stall on both channels.
// Depends on ple_pkg, ple_seq and ple_store.
//
// Requests on in_data_i are taken when in_valid_i is high and in_stall_o low.
// in_stall_o stays high while a request is being worked on; one request is
// processed at a time. Each request yields one result on out_data_o.
// Each request walks the entry store, one entry moved or compared per cycle:
//   an insert at p moves the entries from p to the tail up by one, a
//   delete at p moves the entries above p down by one, and a search compares
//   entries from the head until a match or the end of the list; requests that
//   end in a status only (bounds, full, empty) skip the walk.
// The output register frees the sequencer once a result is handed over, so a
// new request can start while the receiver still stalls the last result;
// a second result waits in the sequencer until the output register drains.
// Reset empties the list at once (length zero); no clearing pass is needed,
// since entries at or above the length are never read.
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ple_req_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ple_result_t out_data_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic          seq_idle;
  logic          start;
  logic          res_valid;
  logic          res_take;
  ple_result_t   res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  logic          out_valid_q;
  ple_result_t   out_data_q;

  // input transfer only while the sequencer is idle
  assign in_stall_o = !seq_idle;
  assign start      = in_valid_i && seq_idle;

  // result moves into the output register when it is empty or draining
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  ple_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (in_data_i),
    .idle_o      (seq_idle),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ple_store #(
    .CAPACITY(CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: hdl/ple_store.sv
// Entry storage for the positional list engine: one write port and one
// registered read port. Depends on nothing but its parameter.
module ple_store #(
  parameter int unsigned CAPACITY = 32,
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [CAPACITY];
  logic [31:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/ple_seq.sv
// Sequencer for the positional list engine: decodes a request, walks the
// entry store one entry per cycle to shift or search, holds the result.
// Depends on ple_pkg and positional_list_engine_assert.svh.
`include "positional_list_engine_assert.svh"

module ple_seq
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = 32,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ple_req_t      req_i,
  output logic          idle_o,
  output logic          res_valid_o,
  output ple_result_t   res_o,
  input  logic          res_take_i,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [31:0]   mem_wdata_o,
  output logic [AW-1:0] mem_raddr_o,
  input  logic [31:0]   mem_rdata_i
);

  // compare width wide enough for both the position field and the count
  localparam int unsigned XW = (CW > 6) ? CW : 6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_FIN,
    S_DEL,
    S_SRCH,
    S_DONE
  } state_e;

  state_e      state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] at_q, at_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] widx_q, widx_d;
  logic          pend_q, pend_d;
  logic [31:0]   val_q, val_d;
  ple_status_e   status_q, status_d;
  logic [4:0]    found_q, found_d;

  logic [XW-1:0] pos_x, cnt_x, at_x;
  logic [CW-1:0] raddr_full, waddr_full;

  assign pos_x = XW'(req_i.position);
  assign cnt_x = XW'(count_q);

  // next-state and memory port logic
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    at_d       = at_q;
    idx_d      = idx_q;
    widx_d     = widx_q;
    pend_d     = pend_q;
    val_d      = val_q;
    status_d   = status_q;
    found_d    = found_q;
    at_x       = '0;
    mem_we_o   = 1'b0;
    waddr_full = widx_q;
    mem_wdata_o = mem_rdata_i;
    raddr_full = idx_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          val_d    = req_i.value;
          status_d = ST_OK;
          found_d  = '0;
          pend_d   = 1'b0;
          case (req_i.kind)
            K_INS_HEAD, K_INS_TAIL, K_INS_AT: begin
              if (req_i.kind == K_INS_HEAD) begin
                at_x = '0;
              end else if (req_i.kind == K_INS_TAIL) begin
                at_x = cnt_x;
              end else begin
                at_x = pos_x;
              end
              if (at_x > cnt_x) begin
                status_d = ST_BOUNDS;
                state_d  = S_DONE;
              end else if (count_q >= CW'(CAPACITY)) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                at_d    = CW'(at_x);
                idx_d   = count_q;
                state_d = S_INS;
              end
            end
            K_DEL_HEAD, K_DEL_TAIL, K_DEL_AT: begin
              if (req_i.kind == K_DEL_HEAD) begin
                at_x = '0;
              end else if (req_i.kind == K_DEL_TAIL) begin
                at_x = cnt_x - XW'(1);
              end else begin
                at_x = pos_x;
              end
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else if (at_x >= cnt_x) begin
                status_d = ST_BOUNDS;
                state_d  = S_DONE;
              end else begin
                idx_d   = CW'(at_x);
                state_d = S_DEL;
              end
            end
            K_SEARCH: begin
              idx_d   = '0;
              state_d = S_SRCH;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // open the gap: move entry idx-1 up to idx, from the tail down
      S_INS: begin
        if (pend_q) begin
          mem_we_o = 1'b1;
        end
        if (idx_q > at_q) begin
          raddr_full = idx_q - CW'(1);
          widx_d     = idx_q;
          idx_d      = idx_q - CW'(1);
          pend_d     = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_INS_FIN;
        end
      end

      S_INS_FIN: begin
        mem_we_o    = 1'b1;
        waddr_full  = at_q;
        mem_wdata_o = val_q;
        count_d     = count_q + CW'(1);
        state_d     = S_DONE;
      end

      // close the gap: move entry idx+1 down to idx, from the position up
      S_DEL: begin
        if (pend_q) begin
          mem_we_o = 1'b1;
        end
        if ((idx_q + CW'(1)) < count_q) begin
          raddr_full = idx_q + CW'(1);
          widx_d     = idx_q;
          idx_d      = idx_q + CW'(1);
          pend_d     = 1'b1;
        end else begin
          pend_d  = 1'b0;
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end
      end

      // linear scan; read data of entry widx is compared in the cycle after its read
      S_SRCH: begin
        if (pend_q && (mem_rdata_i == val_q)) begin
          status_d = ST_OK;
          found_d  = 5'(widx_q);
          pend_d   = 1'b0;
          state_d  = S_DONE;
        end else if (idx_q < count_q) begin
          raddr_full = idx_q;
          widx_d     = idx_q;
          idx_d      = idx_q + CW'(1);
          pend_d     = 1'b1;
        end else begin
          status_d = ST_NOTFOUND;
          pend_d   = 1'b0;
          state_d  = S_DONE;
        end
      end

      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign mem_waddr_o = waddr_full[AW-1:0];
  assign mem_raddr_o = raddr_full[AW-1:0];

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      at_q     <= '0;
      idx_q    <= '0;
      widx_q   <= '0;
      pend_q   <= 1'b0;
      val_q    <= '0;
      status_q <= ST_OK;
      found_q  <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      at_q     <= at_d;
      idx_q    <= idx_d;
      widx_q   <= widx_d;
      pend_q   <= pend_d;
      val_q    <= val_d;
      status_q <= status_d;
      found_q  <= found_d;
    end
  end

  assign idle_o             = (state_q == S_IDLE);
  assign res_valid_o        = (state_q == S_DONE);
  assign res_o.status       = status_q;
  assign res_o.found_index  = found_q;
  assign res_o.length       = 6'(count_q);

  // count only moves while an operation is in flight
  `PLE_ASSERT_NXT(a_count_hold, (state_q == S_IDLE || state_q == S_DONE),
                  (count_q == $past(count_q)), "count changed outside an operation")
  // shifts never write past the capacity
  `PLE_ASSERT_IMP(a_write_range, mem_we_o, (waddr_full < CW'(CAPACITY)),
                  "write beyond capacity")
  // a full status is only reported on a full list
  `PLE_ASSERT_IMP(a_full_status, (state_q == S_DONE && status_q == ST_FULL),
                  (count_q == CW'(CAPACITY)), "full status on a list that is not full")

endmodule
